>>> rtl/scl_pkg.sv
// Shared constants, widths and helper functions for the serial command line parser.
`timescale 1ns / 1ps

package scl_pkg;

  localparam int MAX_COMMANDS = 8;
  localparam int NAME_BYTES   = 8;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = NAME_BYTES * BYTE_W;
  localparam int CAND_W       = 3;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 4;
  localparam int LINE_W       = 2;
  localparam int IDX_W        = 4;
  localparam int ADDR_W       = 6;
  localparam int CFG_IDX_W    = 3;

  localparam int DEF_NUM_COMMANDS = 8;
  localparam int DEF_BUFFER_SIZE  = 64;

  // Stream payload widths; the output tdata width is padded to whole bytes.
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_RAW_W   = 1 + ADDR_W + BYTE_W + 1 + 1 + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0]  NONE_CMD = IDX_W'(8);
  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

  // Item kinds on the input channel.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_sep(input logic [BYTE_W-1:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI);
  endfunction

  // Lowest set bit of a command hit vector: {found, index}.
  function automatic logic [CAND_W:0] first_hit(input logic [MAX_COMMANDS-1:0] hits);
    logic [CAND_W:0] res;
    res = '0;
    for (int k = MAX_COMMANDS - 1; k >= 0; k--) begin
      if (hits[k]) begin
        res = {1'b1, CAND_W'(k)};
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/serial_command_line_parser.sv
// Serial command line parser: line framing, command name match and parameter writes.
`timescale 1ns / 1ps

//  Channel  Direction  Payload (lowest bit first)
//  in_      slave      tuser: kind; tdata: rx_byte
//  out_     master     tdata: write_valid, write_address, write_data, clear_buffer,
//                             message_ready, command_index, zero fill
//  cfg_     slave      cfg_index: register number; cfg_data: command name bytes
//
//  One item per cycle while in_tready is high; its result is registered in the
//  output register, or in the skid entry when that is full. The next parse state
//  and the name compare are combinational. rst_n is synchronous and clears the
//  parse state and all command names. A two-entry output (register plus skid)
//  keeps in_tready high while one result waits, and drops it only when both are full.

module serial_command_line_parser #(
  parameter int NUM_COMMANDS = scl_pkg::DEF_NUM_COMMANDS,
  parameter int BUFFER_SIZE  = scl_pkg::DEF_BUFFER_SIZE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [scl_pkg::IN_TDATA_W-1:0]      in_tdata,   // rx_byte
  input  logic [scl_pkg::IN_TUSER_W-1:0]      in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // write_valid, write_address, write_data, clear_buffer, message_ready, command_index
  output logic [scl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scl_pkg::CMD_W-1:0]           cfg_data
);
  import scl_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_NAME  = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  // Command name registers.
  logic [CMD_W-1:0] cmd_r [NUM_COMMANDS];

  // Parse state.
  phase_t            phase_r, phase_nxt;
  logic              cr_r, cr_nxt;
  logic              skip_r, skip_nxt;
  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              ska_r, ska_nxt;
  logic              rdy_r, rdy_nxt;
  logic [IDX_W-1:0]  held_r, held_nxt;

  // Output register and skid entry.
  logic                   out_valid_r, skid_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, skid_data_r;
  logic [OUT_TDATA_W-1:0] res;

  logic accept, take;
  logic [BYTE_W-1:0] c;
  logic              kind;

  // Per-slot name view; slots beyond NUM_COMMANDS read as empty names.
  logic [BYTE_W-1:0] slot_b   [MAX_COMMANDS][NAME_BYTES];
  logic [LEN_W-1:0]  slot_len [MAX_COMMANDS];
  logic [BYTE_W-1:0] byte_at_pos [MAX_COMMANDS];
  logic [MAX_COMMANDS-1:0] pre_ok, len_eq, in_range, after_cand, from_cand, byte_eq;
  logic [CAND_W:0] f_next_byte, f_next_end, f_from_end;

  logic              wv, clr;
  logic [POS_W-1:0]  wa;
  logic [BYTE_W-1:0] wd;
  logic [POS_W-1:0]  pos_inc;

  assign c    = in_tdata[BYTE_W-1:0];
  assign kind = in_tuser[0];

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign take       = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  always_comb begin
    for (int k = 0; k < MAX_COMMANDS; k++) begin
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (k < NUM_COMMANDS) begin
          slot_b[k][i] = cmd_r[k][BYTE_W*i +: BYTE_W];
        end else begin
          slot_b[k][i] = '0;
        end
      end
    end
  end

  // Name length is the count of bytes ahead of the first zero byte.
  always_comb begin
    for (int k = 0; k < MAX_COMMANDS; k++) begin
      slot_len[k] = LEN_W'(NAME_BYTES);
      for (int i = NAME_BYTES - 1; i >= 0; i--) begin
        if (slot_b[k][i] == '0) begin
          slot_len[k] = LEN_W'(i);
        end
      end
    end
  end

  // Prefix compare of every slot against the current candidate, plus the byte at
  // the current position, all in parallel.
  always_comb begin
    for (int k = 0; k < MAX_COMMANDS; k++) begin
      pre_ok[k] = 1'b1;
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (POS_W'(i) < pos_r && slot_b[k][i] != slot_b[cand_r][i]) begin
          pre_ok[k] = 1'b0;
        end
      end
      if (pos_r < POS_W'(NAME_BYTES)) begin
        byte_at_pos[k] = slot_b[k][pos_r[CAND_W-1:0]];
      end else begin
        byte_at_pos[k] = '0;
      end
      len_eq[k]     = ({{(POS_W-LEN_W){1'b0}}, slot_len[k]} == pos_r);
      in_range[k]   = (k < NUM_COMMANDS);
      after_cand[k] = (IDX_W'(k) > {1'b0, cand_r});
      from_cand[k]  = (IDX_W'(k) >= {1'b0, cand_r});
      byte_eq[k]    = (byte_at_pos[k] == c);
    end
  end

  assign f_next_byte = first_hit(in_range & after_cand & pre_ok & byte_eq);
  assign f_next_end  = first_hit(in_range & after_cand & pre_ok & len_eq);
  assign f_from_end  = first_hit(in_range & from_cand & pre_ok & len_eq);

  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    cr_nxt    = cr_r;
    skip_nxt  = skip_r;
    cand_nxt  = cand_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    ska_nxt   = ska_r;
    rdy_nxt   = rdy_r;
    held_nxt  = held_r;
    wv        = 1'b0;
    wa        = '0;
    wd        = '0;
    clr       = 1'b0;

    if (kind == KIND_CLEAR) begin
      rdy_nxt  = 1'b0;
      held_nxt = NONE_CMD;
      clr      = 1'b1;
    end else if (!rdy_r) begin
      case (phase_r)
        PH_WAIT: begin
          skip_nxt = 1'b0;
          cand_nxt = '0;
          pos_nxt  = '0;
          line_nxt = '0;
          if (c == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (cr_r && c == CH_LF) begin
            phase_nxt = PH_NAME;
            cr_nxt    = 1'b0;
          end else begin
            cr_nxt = 1'b0;
          end
        end
        PH_NAME: begin
          if (!skip_r) begin
            if (is_alnum(c)) begin
              if (c == byte_at_pos[cand_r]) begin
                pos_nxt = pos_inc;
              end else if (f_next_byte[CAND_W]) begin
                cand_nxt = f_next_byte[CAND_W-1:0];
                pos_nxt  = pos_inc;
              end else begin
                skip_nxt = 1'b1;
                ska_nxt  = 1'b0;
                cand_nxt = '0;
                pos_nxt  = '0;
              end
            end else if (is_sep(c)) begin
              if (len_eq[cand_r]) begin
                phase_nxt = PH_PARAM;
                pos_nxt   = '0;
              end else if (f_next_end[CAND_W]) begin
                cand_nxt  = f_next_end[CAND_W-1:0];
                phase_nxt = PH_PARAM;
                pos_nxt   = '0;
              end else begin
                cand_nxt = '0;
                pos_nxt  = '0;
              end
            end else begin
              skip_nxt = 1'b1;
              ska_nxt  = 1'b0;
              if (c == CH_CR) begin
                cr_nxt = 1'b1;
              end
            end
          end else begin
            if (is_sep(c)) begin
              skip_nxt = 1'b0;
              cand_nxt = '0;
              pos_nxt  = '0;
            end else if (c == CH_CR) begin
              cr_nxt = 1'b1;
            end else if (cr_r && c == CH_LF) begin
              // A short line keeps matching names; a full one closes out.
              if (line_r == LINE_MAX) begin
                if (!ska_r && f_from_end[CAND_W]) begin
                  held_nxt = {1'b0, f_from_end[CAND_W-1:0]};
                  rdy_nxt  = 1'b1;
                end else begin
                  held_nxt = NONE_CMD;
                end
                phase_nxt = PH_WAIT;
              end
              cand_nxt = '0;
              pos_nxt  = '0;
              skip_nxt = 1'b0;
              cr_nxt   = 1'b0;
            end else begin
              cr_nxt = 1'b0;
            end
            ska_nxt = 1'b1;
          end
        end
        default: begin
          if (is_sep(c)) begin
            wv      = 1'b1;
            wa      = pos_r;
            wd      = '0;
            pos_nxt = pos_inc;
          end else if (c == CH_CR) begin
            wv      = 1'b1;
            wa      = pos_r;
            wd      = c;
            pos_nxt = pos_inc;
            cr_nxt  = 1'b1;
          end else if (cr_r && c == CH_LF) begin
            // The stored CR becomes the terminating zero.
            cr_nxt = 1'b0;
            if (pos_r != '0) begin
              wv = 1'b1;
              wa = pos_r - 1'b1;
              wd = '0;
            end
            rdy_nxt   = 1'b1;
            held_nxt  = {1'b0, cand_r};
            cand_nxt  = '0;
            pos_nxt   = '0;
            skip_nxt  = 1'b0;
            phase_nxt = PH_WAIT;
          end else begin
            wv      = 1'b1;
            wa      = pos_r;
            wd      = c;
            pos_nxt = pos_inc;
            cr_nxt  = 1'b0;
          end
          if (wv && {1'b0, wa} >= (POS_W+1)'(BUFFER_SIZE)) begin
            wv = 1'b0;
          end
          if (!wv) begin
            wa = '0;
            wd = '0;
          end
        end
      endcase
      if (line_nxt != LINE_MAX) begin
        line_nxt = line_nxt + 1'b1;
      end
    end
  end

  assign res = OUT_TDATA_W'({held_nxt, rdy_nxt, clr, wd, wa[ADDR_W-1:0], wv});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_COMMANDS; k++) begin
        cmd_r[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int k = 0; k < NUM_COMMANDS; k++) begin
        if ({1'b0, cfg_index} == (CFG_IDX_W+1)'(k)) begin
          cmd_r[k] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cr_r    <= 1'b0;
      skip_r  <= 1'b0;
      cand_r  <= '0;
      pos_r   <= '0;
      line_r  <= '0;
      ska_r   <= 1'b0;
      rdy_r   <= 1'b0;
      held_r  <= NONE_CMD;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cr_r    <= cr_nxt;
      skip_r  <= skip_nxt;
      cand_r  <= cand_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      ska_r   <= ska_nxt;
      rdy_r   <= rdy_nxt;
      held_r  <= held_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
        if (accept) begin
          out_data_r <= res;
        end
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end
  end

endmodule
